### hdl/tlik_pkg.sv
`default_nettype none
package tlik_pkg;

	// CORDIC depth, valid range 8 to 24
	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_LAT = CORDIC_STAGES + 9;
	localparam int DIV_STEPS = 17;
	localparam int SQRT_STEPS = 17;
	localparam int PRE_LAT = DIV_STEPS + SQRT_STEPS + 8;
	localparam int TOT_LAT = PRE_LAT + ATAN_LAT + 1;

	// CORDIC datapath widths
	localparam int AW = 46;
	localparam int ZW = 26;
	localparam logic signed [ZW-1:0] QTR_ANGLE = 26'sd4194304;

	typedef enum logic [1:0] {
		REG_L1  = 2'd0,
		REG_L2  = 2'd1,
		REG_MAX = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		C_QUOT,
		C_POS_ONE,
		C_NEG_ONE
	} csel_t;

	// divider stage payload
	typedef struct packed {
		logic [33:0] r;
		logic [16:0] q;
		logic [32:0] d;
		logic        neg;
		csel_t       sel;
		logic        flag;
	} tlik_div_t;

	// square root stage payload
	typedef struct packed {
		logic [18:0]        rem;
		logic [16:0]        root;
		logic [32:0]        v;
		logic signed [17:0] c;
		logic               flag;
	} tlik_sqrt_t;

	// arctangent of 2^-i in units of pi/2^23
	function automatic logic signed [ZW-1:0] atan_step(input int i);
		logic signed [ZW-1:0] r;
		case (i)
			0:  r = 26'sd2097152;
			1:  r = 26'sd1238021;
			2:  r = 26'sd654136;
			3:  r = 26'sd332050;
			4:  r = 26'sd166669;
			5:  r = 26'sd83416;
			6:  r = 26'sd41718;
			7:  r = 26'sd20860;
			8:  r = 26'sd10430;
			9:  r = 26'sd5215;
			10: r = 26'sd2608;
			11: r = 26'sd1304;
			12: r = 26'sd652;
			13: r = 26'sd326;
			14: r = 26'sd163;
			15: r = 26'sd81;
			16: r = 26'sd41;
			17: r = 26'sd20;
			18: r = 26'sd10;
			19: r = 26'sd5;
			20: r = 26'sd3;
			21: r = 26'sd1;
			22: r = 26'sd1;
			default: r = 26'sd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

### hdl/tlik_if.sv
`default_nettype none
interface tlik_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] target_x;
	logic signed [15:0] target_y;
	modport source (output valid, target_x, target_y, input ready);
	modport sink (input valid, target_x, target_y, output ready);
endinterface

interface tlik_out_if;
	logic               valid;
	logic               ready;
	logic signed [16:0] shoulder_angle;
	logic [15:0]        elbow_angle;
	logic               reach_clamped;
	modport source (output valid, shoulder_angle, elbow_angle, reach_clamped, input ready);
	modport sink (input valid, shoulder_angle, elbow_angle, reach_clamped, output ready);
endinterface

interface tlik_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hdl/tlik_atan2.sv
`default_nettype none
module tlik_atan2 (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [35:0] x,
	input  wire logic signed [35:0] y,
	output logic signed [16:0]      angle
);
	import tlik_pkg::*;

	localparam int ZL = 8 + CORDIC_STAGES;

	logic signed [41:0]   nx_s [7];
	logic signed [41:0]   ny_s [7];
	logic [40:0]          nm_s [7];
	logic signed [AW-1:0] cx_s [CORDIC_STAGES+1];
	logic signed [AW-1:0] cy_s [CORDIC_STAGES+1];
	logic signed [ZW-1:0] cz_s [CORDIC_STAGES+1];
	logic                 zr_q [ZL];
	logic [35:0]          ax, ay;
	logic signed [ZW-1:0] zrnd;
	logic signed [AW-1:0] px, py;

	// magnitudes of both operands; the larger one is registered
	assign ax = x[35] ? 36'(-x) : 36'(x);
	assign ay = y[35] ? 36'(-y) : 36'(y);

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s[0] <= 42'(x);
			ny_s[0] <= 42'(y);
			nm_s[0] <= (ax > ay) ? 41'(ax) : 41'(ay);
			zr_q[0] <= (ax == 36'd0) && (ay == 36'd0);
		end
	end

	// zero-operand flag follows the vector
	for (genvar k = 1; k < ZL; k++) begin : g_zr
		always_ff @(posedge clk) begin
			if (en) zr_q[k] <= zr_q[k-1];
		end
	end

	// binary-search normalization: larger magnitude into [2^40, 2^41)
	for (genvar k = 0; k < 6; k++) begin : g_norm
		localparam int SH = 32 >> k;
		always_ff @(posedge clk) begin
			if (en) begin
				if ((nm_s[k] >> (41 - SH)) == 41'd0) begin
					nx_s[k+1] <= nx_s[k] <<< SH;
					ny_s[k+1] <= ny_s[k] <<< SH;
					nm_s[k+1] <= nm_s[k] << SH;
				end else begin
					nx_s[k+1] <= nx_s[k];
					ny_s[k+1] <= ny_s[k];
					nm_s[k+1] <= nm_s[k];
				end
			end
		end
	end

	// quarter turn out of the left half plane
	assign px = AW'(nx_s[6]);
	assign py = AW'(ny_s[6]);
	always_ff @(posedge clk) begin
		if (en) begin
			if (px < 0) begin
				if (py >= 0) begin
					cx_s[0] <= py;
					cy_s[0] <= -px;
					cz_s[0] <= QTR_ANGLE;
				end else begin
					cx_s[0] <= -py;
					cy_s[0] <= px;
					cz_s[0] <= -QTR_ANGLE;
				end
			end else begin
				cx_s[0] <= px;
				cy_s[0] <= py;
				cz_s[0] <= '0;
			end
		end
	end

	// vectoring iterations
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (en) begin
				if (cy_s[i] > 0) begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] + atan_step(i);
				end else begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] - atan_step(i);
				end
			end
		end
	end

	// round to pi/32768 and clamp
	assign zrnd = (cz_s[CORDIC_STAGES] + 26'sd128) >>> 8;
	always_ff @(posedge clk) begin
		if (en) begin
			if (zr_q[ZL-1]) angle <= '0;
			else if (zrnd > 26'sd32768) angle <= 17'sd32768;
			else if (zrnd < -26'sd32768) angle <= -17'sd32768;
			else angle <= 17'(zrnd);
		end
	end

endmodule
`default_nettype wire

### hdl/two_link_ik_angles_top.sv
// Two-link planar inverse kinematics, fully pipelined.
// target (sink): a point (target_x, target_y), signed Q8.8, taken on valid & ready.
// result (source): shoulder_angle, elbow_angle in units of pi/32768 and
//   reach_clamped, set when the point lies outside the arm's annulus.
// cfg (sink): register writes, index 0 first link length, 1 second link length,
//   2 elbow limit; ready is always high. Write only while no point is in flight.
// Throughput: one point per cycle while result is ready. The pipeline depth is set
//   by the 17-step radix-2 cosine divider, the 17-step square root and the three
//   parallel CORDIC arctangent units that follow them.
// All stages advance together; when result is valid and not ready, the whole
//   pipe holds and target.ready drops, so nothing is lost or repeated.
// Reset clears the valid chain and loads the link registers with 7680, 5120
//   and the elbow limit with 32768.
`default_nettype none
module two_link_ik_angles_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tlik_in_if.sink    target,
	tlik_out_if.source result,
	tlik_cfg_if.sink   cfg
);
	import tlik_pkg::*;

	logic [15:0] l1_q, l2_q, max_q;
	logic        vld_q [TOT_LAT];
	logic        adv;

	// stage registers
	logic signed [15:0] tx_q [PRE_LAT];
	logic signed [15:0] ty_q [PRE_LAT];
	logic [31:0]        xx_s1, yy_s1, l1l1_s1, l2l2_s1, l1l2_s1;
	logic signed [34:0] num_s2;
	logic [32:0]        den_s2;
	tlik_div_t          div_s [DIV_STEPS+1];
	logic signed [17:0] c_s4, c_s5;
	logic               flag_s4, flag_s5;
	logic [32:0]        csq_s5;
	tlik_sqrt_t         sq_s [SQRT_STEPS+1];
	logic [32:0]        pls_s7, b_s8;
	logic signed [34:0] plc_s7, a_s8;
	logic [16:0]        s_s7, s_s8;
	logic signed [17:0] c_s7, c_s8;
	logic               flag_s7, flag_s8;
	logic               fl_q [ATAN_LAT];
	logic signed [16:0] shoulder_q;
	logic [15:0]        elbow_q;
	logic               clamp_q;

	logic signed [34:0] nden;
	logic               gt, lt;
	logic [33:0]        nabs;
	logic signed [17:0] cq;
	logic signed [35:0] csq;
	logic signed [16:0] t_ang, e_ang, r_ang;
	logic signed [17:0] r_cl, sh_full;
	logic [16:0]        e_cl;

	// configuration registers
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_q  <= 16'd7680;
			l2_q  <= 16'd5120;
			max_q <= 16'd32768;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_L1:  l1_q <= cfg.data;
				REG_L2:  l2_q <= cfg.data;
				REG_MAX: max_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// global advance: hold everything while the output waits
	assign adv = !vld_q[TOT_LAT-1] || result.ready;
	assign target.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= target.valid;
		end
	end
	for (genvar k = 1; k < TOT_LAT; k++) begin : g_vld
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_q[k] <= 1'b0;
			else if (adv) vld_q[k] <= vld_q[k-1];
		end
	end

	// target point delayed to meet the arctangent units
	always_ff @(posedge clk) begin
		if (adv) begin
			tx_q[0] <= target.target_x;
			ty_q[0] <= target.target_y;
		end
	end
	for (genvar k = 1; k < PRE_LAT; k++) begin : g_txy
		always_ff @(posedge clk) begin
			if (adv) begin
				tx_q[k] <= tx_q[k-1];
				ty_q[k] <= ty_q[k-1];
			end
		end
	end

	// S1: squares and link product
	always_ff @(posedge clk) begin
		if (adv) begin
			xx_s1   <= 32'(target.target_x * target.target_x);
			yy_s1   <= 32'(target.target_y * target.target_y);
			l1l1_s1 <= l1_q * l1_q;
			l2l2_s1 <= l2_q * l2_q;
			l1l2_s1 <= l1_q * l2_q;
		end
	end

	// S2: numerator and denominator of the elbow cosine
	always_ff @(posedge clk) begin
		if (adv) begin
			num_s2 <= $signed({3'b0, xx_s1} + {3'b0, yy_s1} - {3'b0, l1l1_s1}
				- {3'b0, l2l2_s1});
			den_s2 <= {l1l2_s1, 1'b0};
		end
	end

	// S3: range check, magnitude, divider setup
	assign nden = -$signed({2'b00, den_s2});
	assign gt   = num_s2 > $signed({2'b00, den_s2});
	assign lt   = num_s2 < nden;
	assign nabs = num_s2[34] ? 34'(-num_s2) : num_s2[33:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s[0].r    <= nabs + {17'd0, den_s2[32:17]};
			div_s[0].q    <= '0;
			div_s[0].d    <= den_s2;
			div_s[0].neg  <= num_s2[34];
			div_s[0].flag <= gt || lt;
			if (gt) div_s[0].sel <= C_POS_ONE;
			else if (lt) div_s[0].sel <= C_NEG_ONE;
			else if (den_s2 == 33'd0) div_s[0].sel <= C_POS_ONE;
			else div_s[0].sel <= C_QUOT;
		end
	end

	// restoring division of n*2^17 + d by 2d, one quotient bit per stage
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [34:0] t;
		logic [34:0] dd;
		logic        ge;
		assign t  = {div_s[j].r, div_s[j].d[16-j]};
		assign dd = {1'b0, div_s[j].d, 1'b0};
		assign ge = t >= dd;
		always_ff @(posedge clk) begin
			if (adv) begin
				div_s[j+1].r    <= ge ? 34'(t - dd) : 34'(t);
				div_s[j+1].q    <= {div_s[j].q[15:0], ge};
				div_s[j+1].d    <= div_s[j].d;
				div_s[j+1].neg  <= div_s[j].neg;
				div_s[j+1].sel  <= div_s[j].sel;
				div_s[j+1].flag <= div_s[j].flag;
			end
		end
	end

	// S4: signed cosine in Q1.16
	assign cq = $signed({1'b0, div_s[DIV_STEPS].q});
	always_ff @(posedge clk) begin
		if (adv) begin
			flag_s4 <= div_s[DIV_STEPS].flag;
			case (div_s[DIV_STEPS].sel)
				C_POS_ONE: c_s4 <= 18'sd65536;
				C_NEG_ONE: c_s4 <= -18'sd65536;
				default:   c_s4 <= div_s[DIV_STEPS].neg ? -cq : cq;
			endcase
		end
	end

	// S5: cosine squared
	assign csq = c_s4 * c_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			csq_s5  <= csq[32:0];
			c_s5    <= c_s4;
			flag_s5 <= flag_s4;
		end
	end

	// S6: radicand for the sine
	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s[0].v    <= {1'b1, 32'd0} - csq_s5;
			sq_s[0].rem  <= '0;
			sq_s[0].root <= '0;
			sq_s[0].c    <= c_s5;
			sq_s[0].flag <= flag_s5;
		end
	end

	// digit-by-digit square root, one root bit per stage
	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
		logic [33:0] vv;
		logic [20:0] t;
		logic [20:0] trial;
		logic        ge;
		assign vv    = {1'b0, sq_s[j].v};
		assign t     = {sq_s[j].rem, vv[33-2*j -: 2]};
		assign trial = {2'b00, sq_s[j].root, 2'b01};
		assign ge    = t >= trial;
		always_ff @(posedge clk) begin
			if (adv) begin
				sq_s[j+1].rem  <= ge ? 19'(t - trial) : 19'(t);
				sq_s[j+1].root <= {sq_s[j].root[15:0], ge};
				sq_s[j+1].v    <= sq_s[j].v;
				sq_s[j+1].c    <= sq_s[j].c;
				sq_s[j+1].flag <= sq_s[j].flag;
			end
		end
	end

	// S7: second link scaled by sine and cosine
	always_ff @(posedge clk) begin
		if (adv) begin
			pls_s7  <= l2_q * sq_s[SQRT_STEPS].root;
			plc_s7  <= $signed({1'b0, l2_q}) * sq_s[SQRT_STEPS].c;
			s_s7    <= sq_s[SQRT_STEPS].root;
			c_s7    <= sq_s[SQRT_STEPS].c;
			flag_s7 <= sq_s[SQRT_STEPS].flag;
		end
	end

	// S8: reach vector
	always_ff @(posedge clk) begin
		if (adv) begin
			a_s8    <= $signed({3'b000, l1_q, 16'd0}) + plc_s7;
			b_s8    <= pls_s7;
			s_s8    <= s_s7;
			c_s8    <= c_s7;
			flag_s8 <= flag_s7;
		end
	end

	// three arctangent units in parallel
	tlik_atan2 u_tgt (
		.clk   (clk),
		.en    (adv),
		.x     (36'(tx_q[PRE_LAT-1])),
		.y     (36'(ty_q[PRE_LAT-1])),
		.angle (t_ang)
	);

	tlik_atan2 u_elb (
		.clk   (clk),
		.en    (adv),
		.x     (36'(c_s8)),
		.y     ($signed({19'd0, s_s8})),
		.angle (e_ang)
	);

	tlik_atan2 u_rch (
		.clk   (clk),
		.en    (adv),
		.x     (36'(a_s8)),
		.y     ($signed({3'd0, b_s8})),
		.angle (r_ang)
	);

	// clamp flag rides alongside the arctangent units
	always_ff @(posedge clk) begin
		if (adv) fl_q[0] <= flag_s8;
	end
	for (genvar k = 1; k < ATAN_LAT; k++) begin : g_fl
		always_ff @(posedge clk) begin
			if (adv) fl_q[k] <= fl_q[k-1];
		end
	end

	// output stage: combine angles and apply the elbow limit
	assign r_cl    = (r_ang < 0) ? 18'sd0 : 18'(r_ang);
	assign sh_full = 18'(t_ang) - r_cl;
	assign e_cl    = (e_ang < 0) ? 17'd0 : 17'(e_ang);

	always_ff @(posedge clk) begin
		if (adv) begin
			shoulder_q <= sh_full[16:0];
			elbow_q    <= (e_cl > {1'b0, max_q}) ? max_q : e_cl[15:0];
			clamp_q    <= fl_q[ATAN_LAT-1];
		end
	end

	assign result.valid          = vld_q[TOT_LAT-1];
	assign result.shoulder_angle = shoulder_q;
	assign result.elbow_angle    = elbow_q;
	assign result.reach_clamped  = clamp_q;

endmodule
`default_nettype wire

### tb/two_link_ik_angles_checker.sv
`default_nettype none
module two_link_ik_angles_checker
	import tlik_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	tlik_in_if.sink   target_mon,
	tlik_out_if.sink  result_mon,
	tlik_cfg_if.sink  cfg_mon,
	output int        fail_count,
	output int        angles_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [16:0] shoulder;
		logic [15:0]        elbow;
		logic               clamped;
	} joint_angles_t;

	joint_angles_t angle_queue[$];
	logic [15:0]   link1_len;
	logic [15:0]   link2_len;
	logic [15:0]   elbow_limit;

	function automatic longint fshr(longint v, int k);
		return v >>> k;
	endfunction

	function automatic longint mag(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic longint angle_table(int i);
		case (i)
			0:  return 2097152;
			1:  return 1238021;
			2:  return 654136;
			3:  return 332050;
			4:  return 166669;
			5:  return 83416;
			6:  return 41718;
			7:  return 20860;
			8:  return 10430;
			9:  return 5215;
			10: return 2608;
			11: return 1304;
			12: return 652;
			13: return 326;
			14: return 163;
			15: return 81;
			16: return 41;
			17: return 20;
			18: return 10;
			19: return 5;
			20: return 3;
			21: return 1;
			22: return 1;
			default: return 0;
		endcase
	endfunction

	// vectoring CORDIC arctangent, pi/32768 units, clamped to a half turn
	function automatic longint arctan2(longint yi, longint xi);
		longint y, x, z, t, dx, dy, m, r;
		y = yi;
		x = xi;
		z = 0;
		m = (mag(x) > mag(y)) ? mag(x) : mag(y);
		if (m == 0)
			return 0;
		while (m < (64'sd1 <<< 40)) begin
			x = x * 2;
			y = y * 2;
			m = m * 2;
		end
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = 16384 * 256;
			end else begin
				t = x; x = -y; y = t; z = -16384 * 256;
			end
		end
		for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
			dx = fshr(y, i);
			dy = fshr(x, i);
			if (y > 0) begin
				x += dx; y -= dy; z += angle_table(i);
			end else begin
				x -= dx; y += dy; z -= angle_table(i);
			end
		end
		r = fshr(z + 128, 8);
		if (r < -32768) r = -32768;
		if (r > 32768) r = 32768;
		return r;
	endfunction

	function automatic longint int_sqrt(longint v);
		longint res, b;
		res = 0;
		b = 64'sd1 <<< 62;
		while (b > v)
			b = b >>> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >>> 1) + b;
			end else begin
				res = res >>> 1;
			end
			b = b >>> 2;
		end
		return res;
	endfunction

	function automatic joint_angles_t solve_arm(logic signed [15:0] tx,
			logic signed [15:0] ty);
		joint_angles_t a;
		longint x, y, l1, l2, num, den, c, s, elb, rch, q;
		x = tx;
		y = ty;
		l1 = link1_len;
		l2 = link2_len;
		num = x * x + y * y - l1 * l1 - l2 * l2;
		den = 2 * l1 * l2;
		a.clamped = 1'b0;
		if (num > den) begin
			c = 65536; a.clamped = 1'b1;
		end else if (num < -den) begin
			c = -65536; a.clamped = 1'b1;
		end else if (den == 0) begin
			c = 65536;
		end else begin
			q = (mag(num) * 131072 + den) / (2 * den);
			c = (num < 0) ? -q : q;
		end
		s = int_sqrt((64'sd1 <<< 32) - c * c);
		elb = arctan2(s, c);
		if (elb < 0) elb = 0;
		if (elb > 32768) elb = 32768;
		rch = arctan2(l2 * s, l1 * 65536 + l2 * c);
		if (rch < 0) rch = 0;
		if (rch > 32768) rch = 32768;
		if (elb > longint'(elbow_limit))
			elb = elbow_limit;
		a.shoulder = 17'(arctan2(y, x) - rch);
		a.elbow = 16'(elb);
		return a;
	endfunction

	// register shadow, prediction and comparison
	always @(posedge clk or negedge arst_n) begin
		joint_angles_t e;
		if (!arst_n) begin
			link1_len <= 16'd7680;
			link2_len <= 16'd5120;
			elbow_limit <= 16'd32768;
			angle_queue.delete();
			fail_count = 0;
		end else begin
			if (cfg_mon.valid && cfg_mon.ready) begin
				case (cfg_mon.index)
					REG_L1:  link1_len <= cfg_mon.data;
					REG_L2:  link2_len <= cfg_mon.data;
					REG_MAX: elbow_limit <= cfg_mon.data;
					default: ;
				endcase
			end
			if (target_mon.valid && target_mon.ready)
				angle_queue.push_back(solve_arm(target_mon.target_x, target_mon.target_y));
			if (result_mon.valid && result_mon.ready) begin
				if (angle_queue.size() == 0) begin
					$error("unexpected result transaction");
					fail_count = fail_count + 1;
				end else begin
					e = angle_queue.pop_front();
					if (result_mon.shoulder_angle !== e.shoulder) begin
						$error("shoulder_angle exp %0d got %0d", e.shoulder,
							result_mon.shoulder_angle);
						fail_count = fail_count + 1;
					end
					if (result_mon.elbow_angle !== e.elbow) begin
						$error("elbow_angle exp %0d got %0d", e.elbow,
							result_mon.elbow_angle);
						fail_count = fail_count + 1;
					end
					if (result_mon.reach_clamped !== e.clamped) begin
						$error("reach_clamped exp %0b got %0b", e.clamped,
							result_mon.reach_clamped);
						fail_count = fail_count + 1;
					end
				end
			end
		end
		angles_pending = angle_queue.size();
	end
endmodule
`default_nettype wire

### tb/two_link_ik_angles_top_tb.sv
`default_nettype none
module two_link_ik_angles_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tlik_pkg::*;

	localparam int LATENCY = CORDIC_STAGES + 52;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   angles_pending;
	int   cycle_count = 0;
	bit   long_hold = 1'b0;
	int   points_sent = 0;

	tlik_in_if  target();
	tlik_out_if result();
	tlik_cfg_if cfg();

	two_link_ik_angles_top uut (
		.clk(clk), .arst_n(arst_n), .target(target), .result(result), .cfg(cfg));

	two_link_ik_angles_checker chk (
		.clk(clk), .arst_n(arst_n), .target_mon(target), .result_mon(result),
		.cfg_mon(cfg), .fail_count(fail_count), .angles_pending(angles_pending));

	always #4 clk = ~clk;

	initial begin
		target.valid = 1'b0;
		target.target_x = '0;
		target.target_y = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_L1;
		cfg.data = '0;
		result.ready = 1'b0;
	end

	// timeout
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// result-side backpressure, with one long hold after 300 points have been sent
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (points_sent > 300 && !long_hold) begin
				long_hold = 1'b1;
				result.ready <= 1'b0;
				repeat (200) @(posedge clk);
			end
			g = (points_sent < 100) ? 0 : gap_len();
			if (g == 0) begin
				result.ready <= 1'b1;
			end else begin
				result.ready <= 1'b0;
				repeat (g - 1) @(posedge clk);
			end
		end
	end

	task automatic send_point(logic signed [15:0] px, logic signed [15:0] py);
		int g;
		g = (points_sent < 60) ? 0 : gap_len();
		if (g > 0) begin
			target.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		target.valid <= 1'b1;
		target.target_x <= px;
		target.target_y <= py;
		@(posedge clk);
		while (!target.ready) @(posedge clk);
		points_sent++;
	endtask

	task automatic drain_pipe();
		target.valid <= 1'b0;
		@(posedge clk);
		while (angles_pending != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_points(int n);
		int k;
		logic signed [15:0] px, py;
		logic [15:0] l1, l2;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 9);
			l1 = 16'(chk.link1_len);
			l2 = 16'(chk.link2_len);
			if (k < 6) begin
				// mostly near reach: |x| up to l1+l2 with random sign, y random and shifted right
				px = 16'($signed($urandom_range(0, 32'(l1) + 32'(l2))) *
					(($urandom_range(0, 1) == 1) ? 1 : -1));
				py = 16'($urandom_range(0, 65535));
				py = py >>> $urandom_range(0, 6);
			end else begin
				px = 16'($urandom_range(0, 65535));
				py = 16'($urandom_range(0, 65535));
			end
			send_point(px, py);
		end
	endtask

	initial begin
		logic signed [15:0] px;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, origin, exact reach, axes
		send_point(16'sd0, 16'sd0);
		send_point(16'sd32767, 16'sd32767);
		send_point(-16'sd32768, -16'sd32768);
		send_point(-16'sd32768, 16'sd0);
		send_point(16'sd0, -16'sd32768);
		send_point(16'sd12800, 16'sd0);
		send_point(16'sd2560, 16'sd0);
		send_point(16'sd0, 16'sd12800);
		send_point(-16'sd2560, 16'sd0);
		send_point(16'sd5000, -16'sd7000);
		send_point(-16'sd1, 16'sd1);
		send_point(-16'sd1, -16'sd1);
		drain_pipe();

		// zero link lengths
		write_reg(REG_L1, 16'd0);
		write_reg(REG_L2, 16'd0);
		send_point(16'sd0, 16'sd0);
		send_point(16'sd100, 16'sd0);
		drain_pipe();
		write_reg(REG_L2, 16'd300);
		send_point(16'sd0, 16'sd0);
		send_point(16'sd300, 16'sd0);
		send_point(16'sd200, 16'sd5);
		drain_pipe();

		// equal maximal links, tight elbow limit
		write_reg(REG_L1, 16'hFFFF);
		write_reg(REG_L2, 16'hFFFF);
		write_reg(REG_MAX, 16'd0);
		send_point(16'sd32767, -16'sd32768);
		send_point(16'sd0, 16'sd0);
		send_point(16'sd1, 16'sd0);
		random_points(80);
		drain_pipe();

		// settings sweep
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_L1, 16'($urandom_range(1, (ph % 2) ? 65535 : 12000)));
			write_reg(REG_L2, 16'($urandom_range(1, (ph % 2) ? 65535 : 12000)));
			write_reg(REG_MAX, (ph == 2) ? 16'hFFFF :
				16'($urandom_range(0, 32768)));
			random_points(ph == 0 ? 500 : 160);
			drain_pipe();
		end

		// back to reset values
		write_reg(REG_L1, 16'd7680);
		write_reg(REG_L2, 16'd5120);
		write_reg(REG_MAX, 16'd32768);
		random_points(100);
		drain_pipe();

		if (fail_count == 0 && angles_pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
